[rtl/core/phrd_pkg.sv]
// Shared types, constants and helper functions of the PPG heart-rate detector.
// Used by every module of the block; depends on nothing else.
package phrd_pkg;

  localparam int SAMPLE_W = 18;
  localparam int FRAC_W   = 8;
  localparam int PULSE_W  = SAMPLE_W + FRAC_W + 2;
  localparam int TIME_W   = 48;
  localparam int IVL_W    = 24;
  localparam int CFG_W    = 24;
  localparam int CIDX_W   = 3;
  localparam int ENV_W    = 20;
  localparam int BPM_W    = 11;
  localparam int LED_W    = 8;
  localparam int CNT16_W  = 16;
  localparam int ACC_W    = 34;
  localparam int QUO_W    = 30;

  localparam int WIN    = 5;
  localparam int IDX_W  = $clog2(WIN);
  localparam int WCNT_W = $clog2(WIN + 1);

  localparam logic signed [16:0] HP_COEF    = 17'sd62915;
  localparam logic signed [15:0] LP_COEF    = 16'sd14418;
  localparam logic [15:0]        DECAY_FAST = 16'd63570;
  localparam logic [15:0]        DECAY_SLOW = 16'd65208;
  localparam logic [ENV_W-1:0]   ENV_CLIP   = ENV_W'(3000 << FRAC_W);
  localparam logic [ENV_W-1:0]   ENV_FLOOR  = ENV_W'(80 << FRAC_W);
  localparam logic [QUO_W-1:0]   RATE_NUM   = QUO_W'(600000000);
  localparam logic [BPM_W-1:0]   RATE_MAX   = BPM_W'(2047);
  localparam logic [TIME_W-1:0]  HOLD_US    = TIME_W'(5000000);
  localparam logic [LED_W-1:0]   LED_STEP   = 8'h10;
  localparam logic [LED_W-1:0]   LED_MIN    = 8'h30;
  localparam logic [LED_W-1:0]   LED_MAX    = 8'hFF;
  localparam logic [LED_W-1:0]   LED_RESET  = 8'hA0;

  localparam logic signed [47:0] PULSE_MAX_X = 48'sd134217727;
  localparam logic signed [47:0] PULSE_MIN_X = -48'sd134217728;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_SKIN_ON  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SKIN_OFF = 3'd1;
  localparam logic [CIDX_W-1:0] REG_WARMUP   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MIN_IVL  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MAX_IVL  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LED_LOW  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_LED_HIGH = 3'd6;
  localparam logic [CIDX_W-1:0] REG_LED_PER  = 3'd7;

  typedef struct packed {
    logic             load;
    logic             pre;
    logic             hp;
    logic             lp;
    logic             env;
    logic             beat;
    logic             med;
    logic [IDX_W-1:0] med_idx;
    logic             div_start;
    logic             led1;
    logic             led2;
    logic             fin;
    logic             out_load;
  } phrd_cmd_t;

  typedef struct packed {
    logic contact;
    logic detect;
    logic need_med;
    logic led_due;
    logic div_done;
    logic out_free;
  } phrd_status_t;

  function automatic logic signed [PULSE_W-1:0] sat_pulse(input logic signed [47:0] v);
    if (v > PULSE_MAX_X) return PULSE_W'(PULSE_MAX_X);
    if (v < PULSE_MIN_X) return PULSE_W'(PULSE_MIN_X);
    return PULSE_W'(v);
  endfunction

endpackage

[rtl/core/phrd_div.sv]
// Restoring divider for the rate: a fixed numerator over a 24-bit interval.
// One quotient bit per cycle; uses phrd_pkg.
module phrd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [phrd_pkg::IVL_W-1:0] den,
  output logic                       done,
  output logic [phrd_pkg::QUO_W-1:0] quo
);
  import phrd_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [QUO_W-1:0]  num_r, num_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [IVL_W-1:0]  den_r, den_nxt;
  logic [IVL_W-1:0]  rem_r, rem_nxt;
  logic [IVL_W:0]    trial;

  assign trial = {rem_r, num_r[QUO_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(QUO_W);
      num_nxt  = RATE_NUM;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = IVL_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[IVL_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/core/phrd_datapath.sv]
// Datapath of the heart-rate detector: configuration, filter, envelope, beat,
// interval window, LED control and the output register. Uses phrd_pkg, phrd_div.
module phrd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phrd_pkg::phrd_cmd_t           cmd,
  output phrd_pkg::phrd_status_t        status,
  input  logic                          cfg_we,
  input  logic [phrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [phrd_pkg::CFG_W-1:0]    cfg_data,
  input  logic [phrd_pkg::SAMPLE_W-1:0] in_ir_sample,
  input  logic [phrd_pkg::SAMPLE_W-1:0] in_red_sample,
  input  logic [phrd_pkg::TIME_W-1:0]   in_time_us,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [phrd_pkg::SAMPLE_W-1:0] out_ir_raw,
  output logic signed [phrd_pkg::PULSE_W-1:0] out_pulse_signal,
  output logic [phrd_pkg::SAMPLE_W-1:0] out_red_raw,
  output logic [phrd_pkg::BPM_W-1:0]    out_bpm_tenths,
  output logic                          out_on_skin,
  output logic                          out_led_update,
  output logic [phrd_pkg::LED_W-1:0]    out_led_current
);
  import phrd_pkg::*;

  // Configuration registers.
  logic [SAMPLE_W-1:0] skin_on_r, skin_off_r, led_low_r, led_high_r;
  logic [CNT16_W-1:0]  warmup_r, led_per_r;
  logic [IVL_W-1:0]    min_ivl_r, max_ivl_r;

  // Latched input transaction.
  logic [SAMPLE_W-1:0] ir_r, red_r;
  logic [TIME_W-1:0]   time_r;

  // Detector state.
  logic                       contact_r, contact_nxt;
  logic                       primed_r, primed_nxt;
  logic [SAMPLE_W-1:0]        hp_in_r, hp_in_nxt;
  logic signed [PULSE_W-1:0]  hp_out_r, hp_out_nxt;
  logic signed [PULSE_W-1:0]  lp_r, lp_nxt;
  logic [ENV_W-1:0]           env_r, env_nxt;
  logic                       armed_r, armed_nxt;
  logic [TIME_W-1:0]          bt_r, bt_nxt;
  logic                       seen_r, seen_nxt;
  logic [IVL_W-1:0]           ist_r [WIN];
  logic [IVL_W-1:0]           ist_nxt [WIN];
  logic [WCNT_W-1:0]          icnt_r, icnt_nxt;
  logic [WCNT_W-1:0]          islot_r, islot_nxt;
  logic [BPM_W-1:0]           rate_r, rate_nxt;
  logic [CNT16_W-1:0]         ssp_r, ssp_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [CNT16_W-1:0]         acnt_r, acnt_nxt;
  logic [LED_W-1:0]           led_r, led_nxt;

  // Per-transaction working registers.
  logic signed [PULSE_W:0]    hp_sum_r, hp_sum_nxt;
  logic signed [PULSE_W-1:0]  y_r, y_nxt;
  logic                       detect_r, detect_nxt;
  logic                       need_med_r, need_med_nxt;
  logic                       led_due_r, led_due_nxt;
  logic                       low_hit_r, low_hit_nxt;
  logic                       upd_r, upd_nxt;
  logic [IVL_W-1:0]           med_r, med_nxt;
  logic [BPM_W-1:0]           bpm_r, bpm_nxt;

  // Output register.
  logic                       ov_r, ov_nxt;
  logic [SAMPLE_W-1:0]        o_ir_r, o_red_r;
  logic signed [PULSE_W-1:0]  o_pulse_r;
  logic [BPM_W-1:0]           o_bpm_r;
  logic                       o_skin_r, o_upd_r;
  logic [LED_W-1:0]           o_led_r;

  logic                       div_done;
  logic [QUO_W-1:0]           div_quo;

  phrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .den   (med_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Arithmetic of the individual steps.
  logic                      contact_new, prime_now;
  logic signed [PULSE_W:0]   hp_diff;
  logic signed [45:0]        hp_prod, hp_rnd;
  logic signed [PULSE_W:0]   lp_diff;
  logic signed [44:0]        lp_prod, lp_rnd;
  logic signed [PULSE_W-1:0] hp_val, lp_val;
  logic [PULSE_W-1:0]        absy;
  logic                      fast;
  logic [35:0]               decay_prod;
  logic signed [34:0]        y_ext, y20, y100, env7;
  logic                      fire, rearm;
  logic [TIME_W-1:0]         rr, since;
  logic                      rr_ok, late;
  logic [WCNT_W-1:0]         slot_eff;
  logic [WCNT_W-1:0]         icnt_inc;
  logic [WCNT_W-1:0]         rank;
  logic [IVL_W-1:0]          cand;
  logic [CNT16_W-1:0]        cnt_eff;
  logic [ACC_W:0]            lim_low, lim_high;
  logic                      high_hit;
  logic [LED_W-1:0]          led_new;

  assign contact_new = (ir_r >= skin_on_r) ? 1'b1 : (ir_r < skin_off_r) ? 1'b0 : contact_r;
  assign prime_now   = contact_new && !primed_r;
  assign hp_diff     = (PULSE_W+1)'($signed({1'b0, ir_r})) -
                       (PULSE_W+1)'($signed({1'b0, hp_in_r}));
  assign hp_prod     = hp_sum_r * HP_COEF;
  assign hp_rnd      = (hp_prod + 46'sd32768) >>> 16;
  assign hp_val      = sat_pulse(48'(hp_rnd));
  assign lp_diff     = (PULSE_W+1)'(hp_out_r) - (PULSE_W+1)'(lp_r);
  assign lp_prod     = lp_diff * LP_COEF;
  assign lp_rnd      = (lp_prod + 45'sd32768) >>> 16;
  assign lp_val      = sat_pulse(48'(lp_r) + 48'(lp_rnd));

  assign absy        = y_r[PULSE_W-1] ? PULSE_W'(-y_r) : PULSE_W'(y_r);
  assign fast        = (32'(absy) * 32'd10) < (32'(env_r) * 32'd3);
  assign decay_prod  = 36'(env_r) * 36'(fast ? DECAY_FAST : DECAY_SLOW) + 36'd32768;

  assign y_ext       = 35'(y_r);
  assign y20         = y_ext * 35'sd20;
  assign y100        = y_ext * 35'sd100;
  assign env7        = $signed(35'(env_r) * 35'd7);
  assign fire        = !armed_r && (y20 > env7) && (env_r > ENV_FLOOR);
  assign rearm       = armed_r && (y100 < env7);
  assign rr          = time_r - bt_r;
  assign rr_ok       = seen_r && (time_r >= bt_r) && (rr >= TIME_W'(min_ivl_r)) &&
                       (rr <= TIME_W'(max_ivl_r));
  assign slot_eff    = (islot_r < WCNT_W'(WIN)) ? islot_r : '0;
  assign icnt_inc    = (icnt_r < WCNT_W'(WIN)) ? icnt_r + WCNT_W'(1) : icnt_r;

  assign since       = time_r - bt_r;
  assign late        = seen_r && (time_r >= bt_r) && (since > HOLD_US);

  assign cnt_eff     = (acnt_r == '0) ? CNT16_W'(1) : acnt_r;
  assign lim_low     = (ACC_W+1)'(led_low_r) * (ACC_W+1)'(cnt_eff);
  assign lim_high    = ((ACC_W+1)'(led_high_r) + (ACC_W+1)'(1)) * (ACC_W+1)'(cnt_eff);
  assign high_hit    = (ACC_W+1)'(acc_r) >= lim_high;

  always_comb begin
    led_new = led_r;
    if (low_hit_r && led_r < LED_MAX) begin
      led_new = (led_r > LED_MAX - LED_STEP) ? LED_MAX : led_r + LED_STEP;
    end else if (high_hit && led_r > LED_MIN) begin
      led_new = (led_r < LED_MIN + LED_STEP) ? LED_MIN : led_r - LED_STEP;
    end
  end

  // Stable rank of one interval in the window: smaller entries, plus equal
  // entries that sit at a lower position.
  always_comb begin
    rank = '0;
    cand = ist_r[cmd.med_idx];
    for (int j = 0; j < WIN; j++) begin
      if (WCNT_W'(j) < icnt_r) begin
        if (ist_r[j] < cand) begin
          rank = rank + WCNT_W'(1);
        end else if (ist_r[j] == cand && IDX_W'(j) < cmd.med_idx) begin
          rank = rank + WCNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    contact_nxt  = contact_r;
    primed_nxt   = primed_r;
    hp_in_nxt    = hp_in_r;
    hp_out_nxt   = hp_out_r;
    lp_nxt       = lp_r;
    env_nxt      = env_r;
    armed_nxt    = armed_r;
    bt_nxt       = bt_r;
    seen_nxt     = seen_r;
    ist_nxt      = ist_r;
    icnt_nxt     = icnt_r;
    islot_nxt    = islot_r;
    rate_nxt     = rate_r;
    ssp_nxt      = ssp_r;
    acc_nxt      = acc_r;
    acnt_nxt     = acnt_r;
    led_nxt      = led_r;
    hp_sum_nxt   = hp_sum_r;
    y_nxt        = y_r;
    detect_nxt   = detect_r;
    need_med_nxt = need_med_r;
    led_due_nxt  = led_due_r;
    low_hit_nxt  = low_hit_r;
    upd_nxt      = upd_r;
    med_nxt      = med_r;
    bpm_nxt      = bpm_r;

    if (cmd.pre) begin
      contact_nxt  = contact_new;
      y_nxt        = '0;
      upd_nxt      = 1'b0;
      detect_nxt   = 1'b0;
      need_med_nxt = 1'b0;
      led_due_nxt  = 1'b0;
      hp_sum_nxt   = (PULSE_W+1)'(hp_out_r) + (hp_diff <<< FRAC_W);
      if (contact_r && !contact_new) begin
        rate_nxt   = '0;
        icnt_nxt   = '0;
        islot_nxt  = '0;
        seen_nxt   = 1'b0;
        primed_nxt = 1'b0;
        ssp_nxt    = '0;
      end
      if (prime_now) begin
        hp_in_nxt  = ir_r;
        hp_out_nxt = '0;
        lp_nxt     = '0;
        env_nxt    = '0;
        ssp_nxt    = '0;
        rate_nxt   = '0;
        seen_nxt   = 1'b0;
        icnt_nxt   = '0;
        islot_nxt  = '0;
        primed_nxt = 1'b1;
        hp_sum_nxt = '0;
      end
    end

    if (cmd.hp) begin
      hp_out_nxt = hp_val;
      hp_in_nxt  = ir_r;
      if (ssp_r != '1) ssp_nxt = ssp_r + CNT16_W'(1);
    end

    if (cmd.lp) begin
      lp_nxt     = lp_val;
      y_nxt      = lp_val;
      detect_nxt = (ssp_r >= warmup_r);
    end

    if (cmd.env) begin
      if (absy > PULSE_W'(env_r)) begin
        env_nxt = (absy < PULSE_W'(ENV_CLIP)) ? absy[ENV_W-1:0] : ENV_CLIP;
      end else begin
        env_nxt = decay_prod[35:16];
      end
    end

    if (cmd.beat) begin
      if (fire) begin
        armed_nxt = 1'b1;
        if (rr_ok) begin
          ist_nxt[slot_eff[IDX_W-1:0]] = rr[IVL_W-1:0];
          islot_nxt = (slot_eff == WCNT_W'(WIN - 1)) ? '0 : slot_eff + WCNT_W'(1);
          icnt_nxt  = icnt_inc;
          need_med_nxt = (icnt_inc >= WCNT_W'(3));
        end
        bt_nxt   = time_r;
        seen_nxt = 1'b1;
      end else if (rearm) begin
        armed_nxt = 1'b0;
      end
      acc_nxt     = acc_r + ACC_W'(ir_r);
      acnt_nxt    = acnt_r + CNT16_W'(1);
      led_due_nxt = ((acnt_r + CNT16_W'(1)) >= led_per_r);
    end

    if (cmd.med && (WCNT_W'(cmd.med_idx) < icnt_r) && (rank == (icnt_r >> 1))) begin
      med_nxt = cand;
    end

    if (div_done) begin
      rate_nxt = (div_quo > QUO_W'(RATE_MAX)) ? RATE_MAX : div_quo[BPM_W-1:0];
    end

    if (cmd.led1) begin
      low_hit_nxt = (ACC_W+1)'(acc_r) < lim_low;
    end

    if (cmd.led2) begin
      acc_nxt  = '0;
      acnt_nxt = '0;
      if (led_new != led_r) begin
        led_nxt    = led_new;
        upd_nxt    = 1'b1;
        primed_nxt = 1'b0;
      end
    end

    if (cmd.fin) begin
      if (detect_r && late) rate_nxt = '0;
      bpm_nxt = (detect_r && !late) ? rate_r : '0;
    end
  end

  assign ov_nxt = cmd.out_load ? 1'b1 : (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skin_on_r  <= SAMPLE_W'(20000);
      skin_off_r <= SAMPLE_W'(8000);
      warmup_r   <= CNT16_W'(150);
      min_ivl_r  <= IVL_W'(333000);
      max_ivl_r  <= IVL_W'(2000000);
      led_low_r  <= SAMPLE_W'(60000);
      led_high_r <= SAMPLE_W'(180000);
      led_per_r  <= CNT16_W'(200);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIN_ON:  skin_on_r  <= cfg_data[SAMPLE_W-1:0];
        REG_SKIN_OFF: skin_off_r <= cfg_data[SAMPLE_W-1:0];
        REG_WARMUP:   warmup_r   <= cfg_data[CNT16_W-1:0];
        REG_MIN_IVL:  min_ivl_r  <= cfg_data[IVL_W-1:0];
        REG_MAX_IVL:  max_ivl_r  <= cfg_data[IVL_W-1:0];
        REG_LED_LOW:  led_low_r  <= cfg_data[SAMPLE_W-1:0];
        REG_LED_HIGH: led_high_r <= cfg_data[SAMPLE_W-1:0];
        REG_LED_PER:  led_per_r  <= cfg_data[CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_r <= 1'b0;
      primed_r  <= 1'b0;
      hp_in_r   <= '0;
      hp_out_r  <= '0;
      lp_r      <= '0;
      env_r     <= '0;
      armed_r   <= 1'b0;
      bt_r      <= '0;
      seen_r    <= 1'b0;
      icnt_r    <= '0;
      islot_r   <= '0;
      rate_r    <= '0;
      ssp_r     <= '0;
      acc_r     <= '0;
      acnt_r    <= '0;
      led_r     <= LED_RESET;
      ov_r      <= 1'b0;
    end else begin
      contact_r <= contact_nxt;
      primed_r  <= primed_nxt;
      hp_in_r   <= hp_in_nxt;
      hp_out_r  <= hp_out_nxt;
      lp_r      <= lp_nxt;
      env_r     <= env_nxt;
      armed_r   <= armed_nxt;
      bt_r      <= bt_nxt;
      seen_r    <= seen_nxt;
      icnt_r    <= icnt_nxt;
      islot_r   <= islot_nxt;
      rate_r    <= rate_nxt;
      ssp_r     <= ssp_nxt;
      acc_r     <= acc_nxt;
      acnt_r    <= acnt_nxt;
      led_r     <= led_nxt;
      ov_r      <= ov_nxt;
    end
    ist_r      <= ist_nxt;
    hp_sum_r   <= hp_sum_nxt;
    y_r        <= y_nxt;
    detect_r   <= detect_nxt;
    need_med_r <= need_med_nxt;
    led_due_r  <= led_due_nxt;
    low_hit_r  <= low_hit_nxt;
    upd_r      <= upd_nxt;
    med_r      <= med_nxt;
    bpm_r      <= bpm_nxt;
    if (cmd.load) begin
      ir_r   <= in_ir_sample;
      red_r  <= in_red_sample;
      time_r <= in_time_us;
    end
    if (cmd.out_load) begin
      o_ir_r    <= ir_r;
      o_pulse_r <= y_r;
      o_red_r   <= red_r;
      o_bpm_r   <= bpm_r;
      o_skin_r  <= contact_r;
      o_upd_r   <= upd_r;
      o_led_r   <= led_r;
    end
  end

  assign status.contact  = contact_r;
  assign status.detect   = detect_r;
  assign status.need_med = need_med_r;
  assign status.led_due  = led_due_r;
  assign status.div_done = div_done;
  assign status.out_free = !ov_r || !out_stall;

  assign out_valid        = ov_r;
  assign out_ir_raw       = o_ir_r;
  assign out_pulse_signal = o_pulse_r;
  assign out_red_raw      = o_red_r;
  assign out_bpm_tenths   = o_bpm_r;
  assign out_on_skin      = o_skin_r;
  assign out_led_update   = o_upd_r;
  assign out_led_current  = o_led_r;

endmodule

[rtl/core/phrd_ctrl.sv]
// Sequencer of the heart-rate detector: steps the datapath through one
// transaction. Uses phrd_pkg.
module phrd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  phrd_pkg::phrd_status_t status,
  output phrd_pkg::phrd_cmd_t    cmd
);
  import phrd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRE  = 4'd1;
  localparam logic [3:0] ST_HP   = 4'd2;
  localparam logic [3:0] ST_LP   = 4'd3;
  localparam logic [3:0] ST_ENV  = 4'd4;
  localparam logic [3:0] ST_BEAT = 4'd5;
  localparam logic [3:0] ST_MED  = 4'd6;
  localparam logic [3:0] ST_DIVS = 4'd7;
  localparam logic [3:0] ST_DIVW = 4'd8;
  localparam logic [3:0] ST_LED1 = 4'd9;
  localparam logic [3:0] ST_LED2 = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.med_idx = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.pre = 1'b1;
        // Contact is decided during this step, so the branch waits for it.
        state_nxt = ST_HP;
      end
      ST_HP: begin
        if (status.contact) begin
          cmd.hp    = 1'b1;
          state_nxt = ST_LP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_LP: begin
        cmd.lp    = 1'b1;
        state_nxt = ST_ENV;
      end
      ST_ENV: begin
        if (status.detect) begin
          cmd.env   = 1'b1;
          state_nxt = ST_BEAT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_BEAT: begin
        cmd.beat  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_MED;
      end
      ST_MED: begin
        if (!status.need_med) begin
          state_nxt = status.led_due ? ST_LED1 : ST_FIN;
        end else begin
          cmd.med = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(WIN - 1)) state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (status.div_done) state_nxt = status.led_due ? ST_LED1 : ST_FIN;
      end
      ST_LED1: begin
        cmd.led1  = 1'b1;
        state_nxt = ST_LED2;
      end
      ST_LED2: begin
        cmd.led2  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

[rtl/core/ppg_heart_rate_detector.sv]
// Top level of the PPG heart-rate detector: sequencer plus datapath.
// Depends on phrd_pkg, phrd_ctrl, phrd_datapath and phrd_div.
//
// Channel  Direction  Handshake          Contents
// in_      input      in_valid/in_stall  ir_sample, red_sample, time_us
// out_     output     out_valid/out_stall ir_raw, pulse_signal, red_raw,
//                                         bpm_tenths, on_skin, led_update,
//                                         led_current
// cfg_     input      cfg_valid/cfg_ready register index and write data
//
// One transaction is handled at a time. A sample off the skin passes the
// states IDLE, PRE, HP, FIN and OUT; a sample during warmup also LP and ENV;
// a detection sample also BEAT and MED, plus LED1 and LED2 for an LED check,
// and, when a beat updates the rate, median ranking in MED over the window
// and DIVS and DIVW around the 30-step restoring divider.
// Reset is synchronous and active low; it restores the register defaults
// and clears the detector state but for the interval window, with the LED code at 0xA0.
// The output register lets the next input transaction be accepted while a
// result waits on out_stall; processing stalls only when a second result
// is ready before the first one has been taken.
module ppg_heart_rate_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [phrd_pkg::SAMPLE_W-1:0] in_ir_sample,
  input  logic [phrd_pkg::SAMPLE_W-1:0] in_red_sample,
  input  logic [phrd_pkg::TIME_W-1:0]   in_time_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [phrd_pkg::SAMPLE_W-1:0] out_ir_raw,
  output logic signed [phrd_pkg::PULSE_W-1:0] out_pulse_signal,
  output logic [phrd_pkg::SAMPLE_W-1:0] out_red_raw,
  output logic [phrd_pkg::BPM_W-1:0]    out_bpm_tenths,
  output logic                          out_on_skin,
  output logic                          out_led_update,
  output logic [phrd_pkg::LED_W-1:0]    out_led_current,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [phrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [phrd_pkg::CFG_W-1:0]    cfg_data
);
  import phrd_pkg::*;

  phrd_cmd_t    cmd;
  phrd_status_t status;

  // Configuration writes land directly in the datapath registers and are always
  // taken; the system must only write while the detector is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  phrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  phrd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_ir_sample     (in_ir_sample),
    .in_red_sample    (in_red_sample),
    .in_time_us       (in_time_us),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_ir_raw       (out_ir_raw),
    .out_pulse_signal (out_pulse_signal),
    .out_red_raw      (out_red_raw),
    .out_bpm_tenths   (out_bpm_tenths),
    .out_on_skin      (out_on_skin),
    .out_led_update   (out_led_update),
    .out_led_current  (out_led_current)
  );

  // An accepted transaction leaves the sequencer busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // Off the skin the pulse and rate are forced to zero.
  a_off_skin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_on_skin) |-> (out_pulse_signal == '0 && out_bpm_tenths == '0))
    else $error("pulse or rate nonzero off skin");

  // An LED step happens only during detection, hence only on the skin.
  a_led_on_skin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_led_update) |-> out_on_skin)
    else $error("LED update without contact");

  // The LED code never leaves its allowed range.
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_current >= LED_MIN))
    else $error("LED code below minimum");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the PPG heart-rate detector top level.
// Depends on phrd_pkg and ppg_heart_rate_detector; it predicts every result
// with its own model of the detector and compares each output transaction.
module tb;
  import phrd_pkg::*;

  // Clock, reset and every input of the block start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [SAMPLE_W-1:0] in_ir_sample = '0;
  logic [SAMPLE_W-1:0] in_red_sample = '0;
  logic [TIME_W-1:0] in_time_us = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic [SAMPLE_W-1:0] out_ir_raw;
  logic signed [PULSE_W-1:0] out_pulse_signal;
  logic [SAMPLE_W-1:0] out_red_raw;
  logic [BPM_W-1:0] out_bpm_tenths;
  logic out_on_skin;
  logic out_led_update;
  logic [LED_W-1:0] out_led_current;
  logic cfg_ready;

  ppg_heart_rate_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ir_sample(in_ir_sample), .in_red_sample(in_red_sample), .in_time_us(in_time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ir_raw(out_ir_raw), .out_pulse_signal(out_pulse_signal),
    .out_red_raw(out_red_raw), .out_bpm_tenths(out_bpm_tenths),
    .out_on_skin(out_on_skin), .out_led_update(out_led_update),
    .out_led_current(out_led_current),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One expected output transaction.
  typedef struct {
    logic [SAMPLE_W-1:0] ir;
    logic signed [PULSE_W-1:0] pulse;
    logic [SAMPLE_W-1:0] red;
    logic [BPM_W-1:0] bpm;
    logic on_skin;
    logic led_update;
    logic [LED_W-1:0] led;
  } ppg_result_t;

  ppg_result_t expected_results[$];
  int errors = 0;

  // Idle and stall probabilities in percent, plus a long receiver hold-off.
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int out_hold_cycles = 0;

  logic [TIME_W-1:0] t_now = '0;

  // Predicted configuration, at reset defaults.
  logic [17:0] skin_on_lvl = 18'd20000;
  logic [17:0] skin_off_lvl = 18'd8000;
  logic [15:0] warmup_len = 16'd150;
  logic [23:0] min_ivl = 24'd333000;
  logic [23:0] max_ivl = 24'd2000000;
  logic [17:0] led_low = 18'd60000;
  logic [17:0] led_high = 18'd180000;
  logic [15:0] led_period = 16'd200;

  // Predicted detector state, at reset values.
  bit on_contact = 0, is_primed = 0, armed = 0, have_beat = 0;
  logic [17:0] hp_in_last = '0;
  logic signed [27:0] hp_out_last = '0, lp_acc = '0;
  logic [19:0] env_level = '0;
  logic [47:0] last_beat_us = '0;
  logic [23:0] beat_ivls[5];
  logic [2:0] ivl_count = '0, ivl_slot = '0;
  logic [10:0] bpm_hold = '0;
  logic [15:0] since_prime = '0;
  logic [33:0] ir_sum = '0;
  logic [15:0] sum_count = '0;
  logic [7:0] led_drive = LED_RESET;

  function automatic longint round_q16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint clamp_pulse(longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  // Rate from the median of the held beat intervals.
  function automatic logic [10:0] median_bpm();
    longint unsigned s[5];
    longint unsigned key, med;
    int j;
    for (int i = 0; i < ivl_count; i++) s[i] = beat_ivls[i];
    for (int i = 1; i < ivl_count; i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    med = s[ivl_count / 2];
    if (med == 0) return 11'd2047;
    med = 600000000 / med;
    return (med > 2047) ? 11'd2047 : med[10:0];
  endfunction

  // Advances the predicted state by one sample and returns its result.
  task automatic predict_sample(input logic [17:0] ir, input logic [17:0] red,
                                input logic [47:0] now, output ppg_result_t r);
    bit was_on, late;
    longint y, hp, lp;
    longint unsigned absy, env, coef, rr, avg;
    int slot;
    logic [7:0] nc;
    was_on = on_contact;
    y = 0;
    r.bpm = '0;
    r.led_update = 1'b0;
    if (ir >= skin_on_lvl) on_contact = 1;
    else if (ir < skin_off_lvl) on_contact = 0;

    // Leaving the skin drops the rate and the beat history.
    if (was_on && !on_contact) begin
      bpm_hold = '0; ivl_count = '0; ivl_slot = '0;
      have_beat = 0; is_primed = 0; since_prime = '0;
    end

    if (on_contact) begin
      // A new contact, or a step of the LED code, primes the filters.
      if (!is_primed) begin
        hp_in_last = ir; hp_out_last = '0; lp_acc = '0; env_level = '0;
        since_prime = '0; bpm_hold = '0; have_beat = 0;
        ivl_count = '0; ivl_slot = '0; is_primed = 1;
      end
      hp = longint'(hp_out_last) + (longint'(ir) - longint'(hp_in_last)) * 256;
      hp = clamp_pulse(round_q16(hp * longint'(HP_COEF)));
      hp_in_last = ir;
      hp_out_last = hp[27:0];
      lp = longint'(lp_acc);
      lp = clamp_pulse(lp + round_q16((hp - lp) * longint'(LP_COEF)));
      lp_acc = lp[27:0];
      y = lp;
      if (since_prime != 16'hFFFF) since_prime++;

      if (since_prime >= warmup_len) begin
        absy = (y < 0) ? -y : y;
        env = env_level;
        if (absy > env) begin
          env = (absy < 768000) ? absy : 768000;
        end else begin
          coef = (10 * absy < 3 * env) ? DECAY_FAST : DECAY_SLOW;
          env = (env * coef + 32768) >> 16;
        end
        env_level = env[19:0];

        if (!armed && 20 * y > 7 * longint'(env) && env > 20480) begin
          armed = 1;
          // The first beat after priming only records its time.
          if (have_beat && now >= last_beat_us) begin
            rr = now - last_beat_us;
            if (rr >= min_ivl && rr <= max_ivl) begin
              slot = (ivl_slot < 5) ? ivl_slot : 0;
              beat_ivls[slot] = rr[23:0];
              ivl_slot = (slot + 1) % 5;
              if (ivl_count < 5) ivl_count++;
              if (ivl_count >= 3) bpm_hold = median_bpm();
            end
          end
          last_beat_us = now;
          have_beat = 1;
        end else if (armed && 100 * y < 7 * longint'(env)) begin
          armed = 0;
        end

        // No beat for more than five seconds drops the held rate.
        late = have_beat && now >= last_beat_us && (now - last_beat_us) > 5000000;
        if (late) bpm_hold = '0;
        r.bpm = bpm_hold;

        ir_sum = ir_sum + ir;
        sum_count = sum_count + 16'd1;
        if (sum_count >= led_period) begin
          avg = (sum_count != 0) ? ir_sum / sum_count : ir_sum;
          nc = led_drive;
          ir_sum = '0;
          sum_count = '0;
          if (avg < led_low && led_drive < LED_MAX)
            nc = (led_drive > LED_MAX - LED_STEP) ? LED_MAX : led_drive + LED_STEP;
          else if (avg > led_high && led_drive > LED_MIN)
            nc = (led_drive < LED_MIN + LED_STEP) ? LED_MIN : led_drive - LED_STEP;
          if (nc != led_drive) begin
            led_drive = nc;
            r.led_update = 1'b1;
            is_primed = 0;
          end
        end
      end
    end
    r.ir = ir;
    r.pulse = y[27:0];
    r.red = red;
    r.on_skin = on_contact;
    r.led = led_drive;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic check_field(input string what, input longint got, input longint exp);
    if (got != exp) report_mismatch(what, got, exp);
  endtask

  // Sends one sample transaction; the caller is at a rising edge. Valid is
  // only lowered when an idle gap follows, so it never drops and rises in
  // the same step.
  task automatic send_sample(input logic [17:0] ir, input logic [17:0] red,
                             input logic [47:0] now);
    int gap;
    ppg_result_t r;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ir_sample <= ir;
    in_red_sample <= red;
    in_time_us <= now;
    do @(posedge clk); while (in_stall);
    predict_sample(ir, red, now, r);
    expected_results.push_back(r);
  endtask

  // Stops the input and waits until every result has come out, plus the
  // block's worst-case latency.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [23:0] value);
    logic [23:0] data;
    data = value;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SKIN_ON:  skin_on_lvl = data[17:0];
      REG_SKIN_OFF: skin_off_lvl = data[17:0];
      REG_WARMUP:   warmup_len = data[15:0];
      REG_MIN_IVL:  min_ivl = data;
      REG_MAX_IVL:  max_ivl = data;
      REG_LED_LOW:  led_low = data[17:0];
      REG_LED_HIGH: led_high = data[17:0];
      default:      led_period = data[15:0];
    endcase
  endtask

  // Synthetic pulse train: a flat baseline with a raised pulse over the
  // first quarter of each period. Noise samples, time steps backward and
  // long time gaps are mixed in at the given percentage.
  task automatic send_pulse_train(input int count, input int base, input int amp,
                                  input int period, input int dt, input int noise_pct);
    int v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0: t_now = t_now - $urandom_range(1, 100000);
          1: t_now = t_now + 48'd6000000;
          default: ;
        endcase
        send_sample($urandom, $urandom, t_now);
      end else begin
        v = base + (((i % period) < (period + 3) / 4) ? amp : 0) + $urandom_range(0, 63);
        if (v > 262143) v = 262143;
        if (v < 0) v = 0;
        send_sample(v[17:0], $urandom, t_now);
      end
      t_now = t_now + dt;
    end
  endtask

  task automatic set_defaults();
    write_reg(REG_SKIN_ON, 24'd20000);
    write_reg(REG_SKIN_OFF, 24'd8000);
    write_reg(REG_WARMUP, 24'd10);
    write_reg(REG_MIN_IVL, 24'd333000);
    write_reg(REG_MAX_IVL, 24'd2000000);
    write_reg(REG_LED_LOW, 24'd60000);
    write_reg(REG_LED_HIGH, 24'd180000);
    write_reg(REG_LED_PER, 24'd200);
  endtask

  // Field extremes and the contact hysteresis edges.
  task automatic test_directed();
    send_sample(18'd0, 18'h3FFFF, 48'd0);
    send_sample(18'h3FFFF, 18'd0, 48'd10000);
    send_sample(18'h3FFFF, 18'h3FFFF, 48'hFFFF_FFFF_FFFF);
    send_sample(18'd19999, 18'h15555, 48'h8000_0000_0000);
    send_sample(18'd8000, 18'h2AAAA, 48'h5555_5555_5555);
    send_sample(18'd7999, 18'd1, 48'hAAAA_AAAA_AAAA);
    send_sample(18'd19999, 18'd2, 48'hAAAA_AAAA_AAAB);
    send_sample(18'd20000, 18'd3, 48'hAAAA_AAAA_AAAC);
    send_sample(18'h2AAAA, 18'd4, 48'd0);
    send_sample(18'h15555, 18'd5, 48'd1);
    send_sample(18'd0, 18'd6, 48'd2);
    drain_results();
  endtask

  // Regular beats give a held rate; a long gap and time going backwards
  // are added between the pulse trains and mixed in as noise.
  task automatic test_beats();
    set_defaults();
    drain_results();
    t_now = 48'd1000;
    send_pulse_train(120, 100000, 4000, 20, 40000, 2);
    t_now = t_now + 48'd7000000;
    send_pulse_train(20, 100000, 4000, 20, 40000, 0);
    t_now = t_now - 48'd3000000;
    send_pulse_train(20, 100000, 4000, 20, 40000, 0);
    drain_results();
  endtask

  // LED code stepping up to its ceiling and down to its floor.
  task automatic test_led();
    write_reg(REG_WARMUP, 24'd1);
    write_reg(REG_LED_PER, 24'd1);
    write_reg(REG_LED_LOW, 24'h3FFFF);
    write_reg(REG_LED_HIGH, 24'h3FFFF);
    drain_results();
    send_pulse_train(16, 100000, 2000, 8, 40000, 0);
    drain_results();
    write_reg(REG_LED_LOW, 24'd0);
    write_reg(REG_LED_HIGH, 24'd0);
    drain_results();
    send_pulse_train(20, 100000, 2000, 8, 40000, 0);
    drain_results();
    write_reg(REG_LED_PER, 24'd65535);
    drain_results();
    send_pulse_train(6, 100000, 2000, 8, 40000, 0);
    drain_results();
    write_reg(REG_LED_PER, 24'd16);
    write_reg(REG_LED_LOW, 24'd60000);
    write_reg(REG_LED_HIGH, 24'd180000);
    drain_results();
    send_pulse_train(40, 30000, 3000, 10, 40000, 0);
    drain_results();
  endtask

  // Register extremes: constant contact, longest warmup, inverted and
  // widest interval limits.
  task automatic test_config_extremes();
    write_reg(REG_SKIN_ON, 24'd0);
    write_reg(REG_SKIN_OFF, 24'hFFFFFF);
    write_reg(REG_WARMUP, 24'd65535);
    drain_results();
    send_pulse_train(15, 0, 262143, 6, 1000, 20);
    drain_results();
    write_reg(REG_WARMUP, 24'd1);
    write_reg(REG_MIN_IVL, 24'hFFFFFF);
    write_reg(REG_MAX_IVL, 24'd1);
    drain_results();
    send_pulse_train(40, 100000, 5000, 10, 50000, 0);
    drain_results();
    write_reg(REG_MIN_IVL, 24'd1);
    write_reg(REG_MAX_IVL, 24'hFFFFFF);
    write_reg(REG_LED_PER, 24'd65535);
    drain_results();
    send_pulse_train(50, 100000, 5000, 10, 1000, 0);
    drain_results();
  endtask

  // Random pulse trains under one idling mix, with random limits.
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int base;
    drain_results();
    write_reg(REG_SKIN_ON, $urandom_range(15000, 40000) | ($urandom & 24'hFC0000));
    write_reg(REG_SKIN_OFF, $urandom_range(2000, 14000));
    write_reg(REG_WARMUP, $urandom_range(1, 30));
    write_reg(REG_MIN_IVL, $urandom_range(100000, 400000));
    write_reg(REG_MAX_IVL, $urandom_range(1000000, 3000000));
    write_reg(REG_LED_LOW, $urandom_range(40000, 80000));
    write_reg(REG_LED_HIGH, $urandom_range(150000, 200000));
    write_reg(REG_LED_PER, $urandom_range(20, 80));
    drain_results();
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    t_now = {$urandom, $urandom} & 48'h7FFF_FFFF_FFFF;
    for (int k = 0; k < 4; k++) begin
      base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 250000) : $urandom_range(25000, 230000);
      send_pulse_train(30, base, $urandom_range(500, 20000), $urandom_range(8, 40),
                       $urandom_range(20000, 60000), 8);
    end
    drain_results();
    in_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  // The receiver holds off long enough that the block fills and stalls
  // its input; the sender then pauses until every result has arrived.
  task automatic test_backpressure();
    out_hold_cycles = 600;
    send_pulse_train(30, 100000, 4000, 20, 40000, 0);
    drain_results();
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver side: random stalls plus an optional long hold-off that
  // counts down one cycle at a time.
  always @(posedge clk) begin
    if (out_hold_cycles > 0) begin
      out_hold_cycles <= out_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // Each accepted output transaction is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    ppg_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("MISMATCH: output transaction with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("ir_raw", out_ir_raw, e.ir);
        check_field("pulse_signal", out_pulse_signal, e.pulse);
        check_field("red_raw", out_red_raw, e.red);
        check_field("bpm_tenths", out_bpm_tenths, e.bpm);
        check_field("on_skin", out_on_skin, e.on_skin);
        check_field("led_update", out_led_update, e.led_update);
        check_field("led_current", out_led_current, e.led);
      end
    end
  end

  // Upper bound on the run time.
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_beats();
    test_led();
    test_config_extremes();
    test_random_phase(0, 0);
    test_random_phase(56, 0);
    test_random_phase(0, 56);
    test_random_phase(30, 30);
    test_backpressure();
    drain_results();
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
